// ===== rtl/satq_pkg.sv =====
package satq_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   // Reset value of the idle poll register
   localparam logic [7:0] IDLE_POLL_RESET = 8'd3;

   // Input command codes
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_ADD  = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_REJECT = 2'd1;
   localparam logic [1:0] KIND_FIRED  = 2'd2;

   typedef struct packed {
      logic [31:0] expiry;
      logic [15:0] secs;
      logic [7:0]  tag;
   } satq_entry_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic req_ready;
      logic capture;
      logic do_add;
      logic tick_advance;
      logic fire;
      logic load_head;
      logic load_countdown;
   } satq_ctl_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic out_free;
      logic cd_nonzero;
      logic cd_one;
      logic wait_valid;
      logic wait_due;
      logic count_nonzero;
   } satq_sts_type;

   // True when a - b >= 0 as a signed 32-bit difference.
   function automatic logic not_before(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] diff;
      diff = a - b;
      return ~diff[31];
   endfunction

endpackage

// ===== rtl/satq_req_if.sv =====
interface satq_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [15:0] delay_seconds;
   logic [7:0]  alarm_id;

   modport source (output valid, output cmd, output delay_seconds, output alarm_id,
                   input ready);
   modport sink   (input valid, input cmd, input delay_seconds, input alarm_id,
                   output ready);
endinterface

// ===== rtl/satq_rsp_if.sv =====
interface satq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  alarm_id_out;
   logic [15:0] seconds_out;
   logic        last;

   modport source (output valid, output kind, output alarm_id_out, output seconds_out,
                   output last, input ready);
   modport sink   (input valid, input kind, input alarm_id_out, input seconds_out,
                   input last, output ready);
endinterface

// ===== rtl/satq_ctrl.sv =====
module satq_ctrl
   import satq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_cmd,
   input  satq_sts_type sts,
   output satq_ctl_type ctl
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ADD  = 4'b0010,
      ST_TICK = 4'b0100,
      ST_STEP = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            ctl.req_ready = 1'b1;
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = (req_cmd == CMD_ADD) ? ST_ADD : ST_TICK;
            end
         end
         ST_ADD: begin
            if (sts.out_free) begin
               ctl.do_add = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_TICK: begin
            ctl.tick_advance = 1'b1;
            // A countdown that is still running after this tick ends the tick.
            state_in = (sts.cd_nonzero && !sts.cd_one) ? ST_IDLE : ST_STEP;
         end
         ST_STEP: begin
            priority if (sts.wait_valid) begin
               if (!sts.wait_due) begin
                  state_in = ST_IDLE;
               end else if (sts.out_free) begin
                  ctl.fire = 1'b1;
               end
            end else if (sts.count_nonzero) begin
               ctl.load_head = 1'b1;
            end else begin
               ctl.load_countdown = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/satq_dp.sv =====
module satq_dp
   import satq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  satq_ctl_type ctl,
   output satq_sts_type sts,
   input  logic [15:0]  req_delay_seconds,
   input  logic [7:0]   req_alarm_id,
   input  logic         csr_write_enable,
   input  logic [7:0]   csr_write_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [1:0]   rsp_kind,
   output logic [7:0]   rsp_alarm_id_out,
   output logic [15:0]  rsp_seconds_out,
   output logic         rsp_last
);

   logic [7:0]         poll_ff, poll_in;
   logic [31:0]        time_ff, time_in;
   logic [7:0]         cd_ff, cd_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   satq_entry_type     queue_ff [QUEUE_DEPTH];
   satq_entry_type     queue_in [QUEUE_DEPTH];
   satq_entry_type     wait_ff, wait_in;
   logic               wvalid_ff, wvalid_in;
   satq_entry_type     new_ff, new_in;
   logic               ovalid_ff, ovalid_in;
   logic [1:0]         okind_ff, okind_in;
   logic [7:0]         otag_ff, otag_in;
   logic [15:0]        osecs_ff, osecs_in;
   logic               olast_ff, olast_in;

   logic                   full;
   logic                   head_due;
   logic [QUEUE_DEPTH-1:0] insert_here;
   logic [QUEUE_DEPTH-1:0] shift_here;

   assign full     = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign head_due = not_before(time_ff, queue_ff[0].expiry);

   assign sts.out_free      = !ovalid_ff || rsp_ready;
   assign sts.cd_nonzero    = (cd_ff != 8'd0);
   assign sts.cd_one        = (cd_ff == 8'd1);
   assign sts.wait_valid    = wvalid_ff;
   assign sts.wait_due      = not_before(time_ff, wait_ff.expiry);
   assign sts.count_nonzero = (count_ff != '0);

   // Each cell compares itself with the new alarm; the first hit takes it and
   // every occupied cell behind it moves back one place.
   always_comb begin
      logic seen;
      logic below;
      logic hit;
      seen = 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         below          = (COUNT_W'(i) < count_ff);
         hit            = below && not_before(queue_ff[i].expiry, new_ff.expiry);
         insert_here[i] = !seen && (hit || (COUNT_W'(i) == count_ff));
         shift_here[i]  = seen && (COUNT_W'(i) <= count_ff);
         seen           = seen || hit;
      end
   end

   always_comb begin
      poll_in   = csr_write_enable ? csr_write_data : poll_ff;
      time_in   = time_ff;
      cd_in     = cd_ff;
      count_in  = count_ff;
      queue_in  = queue_ff;
      wait_in   = wait_ff;
      wvalid_in = wvalid_ff;
      new_in    = new_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      okind_in  = okind_ff;
      otag_in   = otag_ff;
      osecs_in  = osecs_ff;
      olast_in  = olast_ff;

      if (ctl.capture) begin
         new_in.expiry = time_ff + {16'd0, req_delay_seconds};
         new_in.secs   = req_delay_seconds;
         new_in.tag    = req_alarm_id;
      end

      if (ctl.do_add) begin
         ovalid_in = 1'b1;
         okind_in  = full ? KIND_REJECT : KIND_ACCEPT;
         otag_in   = new_ff.tag;
         osecs_in  = new_ff.secs;
         olast_in  = 1'b1;
         if (!full) begin
            count_in = count_ff + COUNT_W'(1);
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               if (insert_here[i]) begin
                  queue_in[i] = new_ff;
               end else if (shift_here[i]) begin
                  queue_in[i] = queue_ff[(i == 0) ? 0 : i - 1];
               end
            end
         end
      end

      if (ctl.tick_advance) begin
         time_in = time_ff + 32'd1;
         if (cd_ff != 8'd0) begin
            cd_in = cd_ff - 8'd1;
         end
      end

      if (ctl.fire) begin
         wvalid_in = 1'b0;
         ovalid_in = 1'b1;
         okind_in  = KIND_FIRED;
         otag_in   = wait_ff.tag;
         osecs_in  = wait_ff.secs;
         // Another fire follows only when the next head is already due.
         olast_in  = !(sts.count_nonzero && head_due);
      end

      if (ctl.load_head) begin
         wait_in   = queue_ff[0];
         wvalid_in = 1'b1;
         count_in  = count_ff - COUNT_W'(1);
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            queue_in[i] = queue_ff[i + 1];
         end
      end

      if (ctl.load_countdown) begin
         cd_in = poll_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_ff   <= IDLE_POLL_RESET;
         time_ff   <= 32'd0;
         cd_ff     <= 8'd0;
         count_ff  <= '0;
         wvalid_ff <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         poll_ff   <= poll_in;
         time_ff   <= time_in;
         cd_ff     <= cd_in;
         count_ff  <= count_in;
         wvalid_ff <= wvalid_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
      wait_ff  <= wait_in;
      new_ff   <= new_in;
      okind_ff <= okind_in;
      otag_ff  <= otag_in;
      osecs_ff <= osecs_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid        = ovalid_ff;
   assign rsp_kind         = okind_ff;
   assign rsp_alarm_id_out = otag_ff;
   assign rsp_seconds_out  = osecs_ff;
   assign rsp_last         = olast_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_fire_needs_wait: assert property (@(posedge clock) disable iff (reset)
      ctl.fire |-> (wvalid_ff && sts.out_free))
      else $error("fire without a waiting alarm or a free output");

   a_head_needs_empty_slot: assert property (@(posedge clock) disable iff (reset)
      ctl.load_head |-> (!wvalid_ff && count_ff != '0))
      else $error("head taken into an occupied slot or from an empty queue");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (ctl.do_add && !full) |=> (count_ff == $past(count_ff) + COUNT_W'(1)))
      else $error("accepted add did not grow the queue");

endmodule

// ===== rtl/sorted_alarm_timer_queue_top.sv =====
// Channel  Direction  Payload                                      Transfer when
// req      in         cmd, delay_seconds, alarm_id                 req.valid && req.ready
// rsp      out        kind, alarm_id_out, seconds_out, last        rsp.valid && rsp.ready
// csr      in         csr_write_data (idle_poll_ticks)             csr_write_enable
//
// An add: the transfer cycle captures it, then the ADD state does the sorted insert into
// the cell row once the result register is free. A tick ends after the TICK state while
// the idle countdown still runs; else STEP takes heads into the waiting slot and fires.
// Items are handled one at a time: req.ready is high only while the sequencer is idle.
// A held result stalls only the next add or fire; the result register frees as it is taken.
// Reset is synchronous and active high; the queue cells themselves are not cleared.

module sorted_alarm_timer_queue_top
   import satq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   satq_req_if.sink   req,
   satq_rsp_if.source rsp,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   satq_ctl_type ctl;
   satq_sts_type sts;

   // The sequencer decides, step by step, whether to insert, advance time,
   // fire the waiting alarm, refill the slot from the queue head or restart
   // the idle poll countdown.
   satq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_cmd   (req.cmd),
      .sts       (sts),
      .ctl       (ctl)
   );

   assign req.ready = ctl.req_ready;

   // The datapath holds time, the sorted cell row, the waiting slot and the
   // result register that decouples the two sides.
   satq_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .req_delay_seconds (req.delay_seconds),
      .req_alarm_id      (req.alarm_id),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp.valid),
      .rsp_ready         (rsp.ready),
      .rsp_kind          (rsp.kind),
      .rsp_alarm_id_out  (rsp.alarm_id_out),
      .rsp_seconds_out   (rsp.seconds_out),
      .rsp_last          (rsp.last)
   );

endmodule
